// ===== rtl/bhpq_pkg.sv =====
// Shared types, codes and sizing for the binary min-heap priority queue core.
`timescale 1ns / 1ps
package bhpq_pkg;

  localparam int CAPACITY      = 64;
  localparam int CNT_W         = $clog2(CAPACITY + 1);
  localparam int KEY_W         = 32;
  localparam int ENTRY_COUNT_W = 7;
  localparam int STATUS_W      = 2;
  localparam int OUT_DATA_W    = 40;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Broadcast from the controller to every cell of the row.
  typedef struct packed {
    logic push;
    logic pop;
    key_t key;
  } cell_ctl_t;

endpackage

// ===== rtl/bhpq_cell.sv =====
// One cell of the sorted key row: holds one key, shifts in from either neighbor.
`timescale 1ns / 1ps
module bhpq_cell import bhpq_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occ,        // cell holds a live key
  input  logic      left_gt,    // left neighbor's key is above the pushed key
  input  key_t      left_key,
  input  key_t      right_key,
  output logic      self_gt,    // own key is above the pushed key (or cell is free)
  output key_t      key_r
);

  key_t key_nxt;

  assign self_gt = !occ || (key_r > ctl.key);

  always_comb begin
    key_nxt = key_r;
    if (ctl.push) begin
      // Make room: the pushed key lands at the first cell that is free or whose key exceeds it.
      if (left_gt) begin
        key_nxt = left_key;
      end else if (self_gt) begin
        key_nxt = ctl.key;
      end
    end else if (ctl.pop) begin
      key_nxt = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

// ===== rtl/binary_min_heap_priority_queue_core.sv =====
// Top level of the min priority queue: controller, cell row and result register.
//
//  channel | direction | tdata (low bit up)                      | tuser
//  --------+-----------+-----------------------------------------+--------------
//  in_     | slave     | key[31:0]                               | command
//  out_    | master    | min_key[31:0], is_empty, entry_count    | status[1:0]
//
//  A push or pop updates the whole cell row on the clock edge that accepts the
//  word, set by the broadcast key compare in every cell.
//  Reset clears the entry count and the result valid flag; the cell keys need
//  no clearing since only occupied cells are ever reported.
//  in_tready drops only while a result word is held and out_tready is low.
`timescale 1ns / 1ps
module binary_min_heap_priority_queue_core import bhpq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [KEY_W-1:0]         in_tdata,   // key[31:0]
  input  logic                     in_tuser,   // command
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_W-1:0]    out_tdata,  // min_key[31:0], is_empty, entry_count[6:0]
  output logic [STATUS_W-1:0]      out_tuser   // status[1:0]
);

  cnt_t      cnt_r, cnt_nxt;
  logic      out_valid_r, out_valid_nxt;
  status_t   status_r, status_nxt;
  key_t      min_r, min_nxt;
  logic      empty_r, empty_nxt;
  cnt_t      count_r, count_nxt;

  cell_ctl_t ctl;
  key_t      keys [CAPACITY];
  logic      gts  [CAPACITY];

  logic      in_fire;
  cmd_t      cmd;
  key_t      in_key;
  logic      is_full;
  logic      is_zero;

  assign in_fire = in_tvalid && in_tready;
  assign cmd     = cmd_t'(in_tuser);
  assign in_key  = key_t'(in_tdata);
  assign is_full = (cnt_r == CNT_W'(CAPACITY));
  assign is_zero = (cnt_r == '0);

  // Accept a new word whenever the result slot is free or draining this cycle.
  assign in_tready = !out_valid_r || out_tready;

  // Controller: decide the row operation and the result word.
  always_comb begin
    ctl.push   = 1'b0;
    ctl.pop    = 1'b0;
    ctl.key    = in_key;
    cnt_nxt    = cnt_r;
    status_nxt = status_r;
    min_nxt    = min_r;
    empty_nxt  = empty_r;
    count_nxt  = count_r;
    out_valid_nxt = out_valid_r && !out_tready;

    if (in_fire) begin
      out_valid_nxt = 1'b1;
      status_nxt    = ST_DONE;
      unique case (cmd)
        CMD_PUSH: begin
          if (is_full) begin
            status_nxt = ST_FULL;
            min_nxt    = keys[0];
          end else begin
            ctl.push = 1'b1;
            cnt_nxt  = cnt_r + 1'b1;
            // New root is the pushed key when the queue is empty or it undercuts the current one.
            min_nxt  = (is_zero || (keys[0] > in_key)) ? in_key : keys[0];
          end
        end
        CMD_POP: begin
          if (is_zero) begin
            status_nxt = ST_EMPTY;
            min_nxt    = '0;
          end else begin
            ctl.pop = 1'b1;
            cnt_nxt = cnt_r - 1'b1;
            // Report zero once the last key leaves.
            min_nxt = (cnt_r == CNT_W'(1)) ? key_t'(0) : keys[1];
          end
        end
        default: begin
          status_nxt = ST_DONE;
        end
      endcase
      empty_nxt = (cnt_nxt == '0);
      count_nxt = cnt_nxt;
    end
  end

  // Row of cells, sorted ascending from cell 0 (the minimum).
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic left_gt_w;
    key_t left_key_w;
    key_t right_key_w;

    if (i == 0) begin : g_head
      assign left_gt_w  = 1'b0;
      assign left_key_w = in_key;
    end else begin : g_body
      assign left_gt_w  = gts[i-1];
      assign left_key_w = keys[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_key_w = keys[i];
    end else begin : g_mid
      assign right_key_w = keys[i+1];
    end

    bhpq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (CNT_W'(i) < cnt_r),
      .left_gt   (left_gt_w),
      .left_key  (left_key_w),
      .right_key (right_key_w),
      .self_gt   (gts[i]),
      .key_r     (keys[i])
    );
  end

  // Control state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload of the result word: hold while stalled.
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    min_r    <= min_nxt;
    empty_r  <= empty_nxt;
    count_r  <= count_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {ENTRY_COUNT_W'(count_r), empty_r, min_r};

  // Count never runs past capacity.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  // An accepted push into a non-full queue adds exactly one entry.
  a_push_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && cmd == CMD_PUSH && !is_full) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("push did not advance entry count");

  // The two lowest occupied cells stay ordered.
  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r >= CNT_W'(2)) |-> (keys[0] <= keys[1]))
    else $error("cell row out of order");

  // A rejected push reports a full queue.
  a_full_rpt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_FULL) |-> (count_r == CNT_W'(CAPACITY)))
    else $error("full status with room left");

  // Empty flag agrees with the reported count.
  a_empty_rpt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (empty_r == (count_r == '0)))
    else $error("empty flag disagrees with count");

endmodule

// ===== sim/tb_binary_min_heap_priority_queue_core.sv =====
// Self-checking testbench for the binary min-heap priority queue core.
`timescale 1ns / 1ps
module tb_binary_min_heap_priority_queue_core import bhpq_pkg::*; ();

  localparam int  CLK_HALF     = 6;
  localparam int  RESET_CYCLES = 7;
  localparam int  RAND_WORDS   = 1200;
  localparam int  SEG_LEN      = 90;
  localparam int  TAIL_CYCLES  = 40;
  localparam int  CYCLE_LIMIT  = 400000;
  localparam key_t KEY_MAX     = 32'sh7FFF_FFFF;
  localparam key_t KEY_MIN     = 32'sh8000_0000;

  typedef struct {
    status_t                  status;
    key_t                     min_key;
    logic                     is_empty;
    logic [ENTRY_COUNT_W-1:0] entry_count;
  } heap_result_t;

  typedef struct {
    cmd_t         cmd;
    key_t         key;
    bit           typed;
    heap_result_t result;
  } stim_row_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [KEY_W-1:0]      in_tdata   = '0;
  logic                  in_tuser   = CMD_PUSH;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;

  // Mirror of the heap contents, kept in step with every accepted word.
  key_t         heap_keys [1:CAPACITY];
  int           heap_fill = 0;
  heap_result_t pending_results [$];
  stim_row_t    directed_rows [$];

  bit           row_typed = 1'b0;
  heap_result_t row_result;
  int           src_idle_pct = 0;
  int           snk_idle_pct = 0;
  int           error_count  = 0;
  int           cycle_count  = 0;

  binary_min_heap_priority_queue_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #(CLK_HALF) clk = ~clk;

  function automatic void swap_keys(int a, int b);
    key_t t;
    t            = heap_keys[a];
    heap_keys[a] = heap_keys[b];
    heap_keys[b] = t;
  endfunction

  // Apply one push or pop to the mirror heap and return the word it should produce.
  function automatic heap_result_t apply_heap_op(cmd_t cmd, key_t key);
    heap_result_t r;
    int           pos;
    int           pick;
    r.status = ST_DONE;
    if (cmd == CMD_PUSH) begin
      if (heap_fill >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        heap_fill++;
        heap_keys[heap_fill] = key;
        pos = heap_fill;
        // sift up: ties stay below their parent
        while (pos > 1 && heap_keys[pos/2] > heap_keys[pos]) begin
          swap_keys(pos/2, pos);
          pos = pos / 2;
        end
      end
    end else if (heap_fill == 0) begin
      r.status = ST_EMPTY;
    end else if (heap_fill == 1) begin
      heap_fill = 0;
    end else begin
      heap_keys[1] = heap_keys[heap_fill];
      heap_fill--;
      pos = 1;
      // sift down: a child equal to the current choice still wins
      forever begin
        pick = pos;
        if (2*pos <= heap_fill && !(heap_keys[2*pos] > heap_keys[pick]))
          pick = 2*pos;
        if (2*pos+1 <= heap_fill && !(heap_keys[2*pos+1] > heap_keys[pick]))
          pick = 2*pos + 1;
        if (pick == pos)
          break;
        swap_keys(pos, pick);
        pos = pick;
      end
    end
    r.min_key     = (heap_fill > 0) ? heap_keys[1] : '0;
    r.is_empty    = (heap_fill == 0);
    r.entry_count = heap_fill[ENTRY_COUNT_W-1:0];
    return r;
  endfunction

  function automatic void add_row(cmd_t cmd, key_t key, bit typed = 1'b0,
                                  status_t st = ST_DONE, key_t mk = '0,
                                  logic em = 1'b0, logic [ENTRY_COUNT_W-1:0] n = '0);
    stim_row_t row;
    row.cmd                = cmd;
    row.key                = key;
    row.typed              = typed;
    row.result.status      = st;
    row.result.min_key     = mk;
    row.result.is_empty    = em;
    row.result.entry_count = n;
    directed_rows.push_back(row);
  endfunction

  // Mix of tie-prone small keys, extremes and full-range keys.
  function automatic key_t pick_key();
    key_t k;
    case ($urandom_range(0, 7))
      0, 1: k = $signed($urandom_range(0, 6)) - 3;
      2: begin
        case ($urandom_range(0, 3))
          0: k = KEY_MIN;
          1: k = KEY_MAX;
          2: k = '0;
          default: k = -1;
        endcase
      end
      default: k = $urandom;
    endcase
    return k;
  endfunction

  // Present one word at the falling edge, after any random idle cycles, and
  // hold it until the handshake completes.
  task automatic send_word(stim_row_t row);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid  <= 1'b1;
    in_tuser   <= row.cmd;
    in_tdata   <= row.key;
    row_typed  <= row.typed;
    row_result <= row.result;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid and hold off until every expected word has come back.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
  endtask

  always @(negedge clk) begin
    out_tready <= rst_n && ($urandom_range(0, 99) >= snk_idle_pct);
  end

  // Predict on input acceptance, compare on output acceptance.
  always @(posedge clk) begin
    heap_result_t predicted;
    heap_result_t want;
    heap_result_t got;
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predicted = apply_heap_op(cmd_t'(in_tuser), key_t'(in_tdata));
        pending_results.push_back(row_typed ? row_result : predicted);
      end
      if (out_tvalid && out_tready) begin
        got.status      = status_t'(out_tuser);
        got.min_key     = out_tdata[KEY_W-1:0];
        got.is_empty    = out_tdata[KEY_W];
        got.entry_count = out_tdata[KEY_W+ENTRY_COUNT_W:KEY_W+1];
        if (pending_results.size() == 0) begin
          $display({"%0t: unexpected result word: expected none, ",
                    "actual status %0d min %0d empty %0b count %0d"},
                   $time, got.status, got.min_key, got.is_empty, got.entry_count);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, got.status);
            error_count++;
          end
          if (got.min_key !== want.min_key) begin
            $display("%0t: min_key mismatch: expected %0d, actual %0d",
                     $time, want.min_key, got.min_key);
            error_count++;
          end
          if (got.is_empty !== want.is_empty) begin
            $display("%0t: is_empty mismatch: expected %0b, actual %0b",
                     $time, want.is_empty, got.is_empty);
            error_count++;
          end
          if (got.entry_count !== want.entry_count) begin
            $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                     $time, want.entry_count, got.entry_count);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    stim_row_t row;
    int        push_pct;

    // Directed: empty pop, extremes, sole-entry pop, ties, then drain to empty.
    add_row(CMD_POP,  32'sh1234_5678, 1'b1, ST_EMPTY, '0,      1'b1, 7'd0);
    add_row(CMD_PUSH, KEY_MAX,        1'b1, ST_DONE,  KEY_MAX, 1'b0, 7'd1);
    add_row(CMD_POP,  '0,             1'b1, ST_DONE,  '0,      1'b1, 7'd0);
    add_row(CMD_PUSH, KEY_MIN,        1'b1, ST_DONE,  KEY_MIN, 1'b0, 7'd1);
    add_row(CMD_PUSH, KEY_MAX);
    add_row(CMD_PUSH, '0);
    add_row(CMD_PUSH, -1);
    add_row(CMD_PUSH, 5);
    add_row(CMD_PUSH, 5);
    add_row(CMD_PUSH, 5);
    add_row(CMD_PUSH, 32'sh5555_5555);
    add_row(CMD_PUSH, 32'shAAAA_AAAA);
    add_row(CMD_PUSH, -7);
    for (int i = 0; i < 10; i++)
      add_row(CMD_POP, (i % 2) ? KEY_MIN : KEY_MAX);
    add_row(CMD_POP,  -1,             1'b1, ST_EMPTY, '0,      1'b1, 7'd0);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    src_idle_pct = 18;
    snk_idle_pct = 88;
    foreach (directed_rows[i])
      send_word(directed_rows[i]);

    // Pause the sender until the queue of expected words runs dry.
    drain_results();

    row.typed = 1'b0;
    for (int i = 0; i < RAND_WORDS; i++) begin
      if (i == RAND_WORDS / 3) begin
        src_idle_pct = 88;
        snk_idle_pct = 18;
      end else if (i == 2 * RAND_WORDS / 3) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      // Alternate fill-heavy and drain-heavy segments so the heap runs
      // between empty and full, with mixed segments in between.
      case ((i / SEG_LEN) % 4)
        0: push_pct = 95;
        2: push_pct = 8;
        default: push_pct = 50;
      endcase
      row.cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
      row.key = pick_key();
      send_word(row);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bhpq_pkg.sv
rtl/bhpq_cell.sv
rtl/binary_min_heap_priority_queue_core.sv
sim/tb_binary_min_heap_priority_queue_core.sv
